// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg: shared definitions for the phase shift pixel decoder
// Widths, register indexes, the arctangent table and the sideband record
// that travels down the pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int PHASE_BITS_DEF = 16;
	localparam int ATAN_N         = 32;
	// CORDIC datapath width: operands are scaled by 2^16 and grow by the CORDIC gain.
	localparam int CORD_W         = 29;
	localparam int SUM_W          = 10;
	localparam int PROD_W         = 18;

	localparam logic [17:0] SQRT3_Q16   = 18'd113512;
	localparam logic [7:0]  LIMIT_RESET = 8'd26;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [31:0] ATAN_Q32 [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef enum logic [0:0] {
		REG_FOUR_STEP   = 1'b0,
		REG_NOISE_LIMIT = 1'b1
	} psd_reg_t;

	typedef struct packed {
		logic       bg;
		logic       zero;
		logic [7:0] hi;
		logic [7:0] span;
	} psd_side_t;

endpackage

// ===== rtl/core/psd_cordic.sv =====
// ----------------------------------------------------------------------------
// psd_cordic: pipelined vectoring CORDIC
// One micro-rotation per stage; returns the accumulated angle in turns.
// ----------------------------------------------------------------------------
module psd_cordic #(
	parameter int PHASE_BITS = psd_pkg::PHASE_BITS_DEF
) (
	input  logic                              clk,
	input  logic [PHASE_BITS-1:0]             en,
	input  logic signed [psd_pkg::CORD_W-1:0] x_in,
	input  logic signed [psd_pkg::CORD_W-1:0] y_in,
	input  logic signed [PHASE_BITS:0]        ang_in,
	output logic signed [PHASE_BITS:0]        ang_out
);

	localparam int CW = psd_pkg::CORD_W;
	localparam int AW = PHASE_BITS + 1;

	// Table entry rounded half up to PHASE_BITS-1 fractional bits of a turn.
	function automatic logic signed [AW-1:0] step_of(input int i);
		logic [32:0] t;
		t = {1'b0, psd_pkg::ATAN_Q32[i]} + (33'd1 << (32 - PHASE_BITS));
		return $signed(AW'(t >> (33 - PHASE_BITS)));
	endfunction

	logic signed [CW-1:0] x_s [PHASE_BITS];
	logic signed [CW-1:0] y_s [PHASE_BITS];
	logic signed [AW-1:0] a_s [PHASE_BITS];

	logic signed [CW-1:0] xp [PHASE_BITS];
	logic signed [CW-1:0] yp [PHASE_BITS];
	logic signed [AW-1:0] ap [PHASE_BITS];

	always_comb begin
		xp[0] = x_in;
		yp[0] = y_in;
		ap[0] = ang_in;
		for (int i = 1; i < PHASE_BITS; i++) begin
			xp[i] = x_s[i-1];
			yp[i] = y_s[i-1];
			ap[i] = a_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PHASE_BITS; i++) begin
			if (en[i]) begin
				if (yp[i] > 0) begin
					x_s[i] <= xp[i] + (yp[i] >>> i);
					y_s[i] <= yp[i] - (xp[i] >>> i);
					a_s[i] <= ap[i] + step_of(i);
				end else begin
					x_s[i] <= xp[i] - (yp[i] >>> i);
					y_s[i] <= yp[i] + (xp[i] >>> i);
					a_s[i] <= ap[i] - step_of(i);
				end
			end
		end
	end

	assign ang_out = a_s[PHASE_BITS-1];

endmodule

// ===== rtl/core/phase_shift_pixel_decode.sv =====
// ----------------------------------------------------------------------------
// phase_shift_pixel_decode: per-pixel fringe phase decoder
// Background mask, wrapped phase, brightest sample and span for one pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel carries one pixel's intensities from the
//   three (or four) fringe images. Each request on the m_ channel returns the
//   background flag on m_tuser and the wrapped phase, brightest sample and
//   intensity span on m_tdata.
//   The stages, in order: min/max and sums, threshold multiply and operand
//   scaling, quadrant fold, one CORDIC stage per phase bit, then rounding.
//   One pixel is taken every cycle unless the pipe is full and stalled; the
//   CORDIC stage count sets the latency, and nothing in the pipe iterates.
//   Each stage holds its request while the next stage is full and stalled, so
//   empty slots close up when m_tready is low and s_tready drops only when
//   every stage holds a request. Nothing is dropped or repeated.
//   Reset clears the valid bits and sets three-step mode with a noise ratio
//   limit of 26/256. The user must write the configuration registers through
//   cfg_we/cfg_addr/cfg_wdata only while the pipeline is empty; nothing checks it.
// ----------------------------------------------------------------------------
module phase_shift_pixel_decode #(
	parameter int PHASE_BITS = psd_pkg::PHASE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_a, sample_b, sample_c, sample_d
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // wrapped_phase, brightest, intensity_span
	output logic        m_tuser,   // is_background
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int CW = psd_pkg::CORD_W;
	localparam int AW = PHASE_BITS + 1;
	localparam int NS = PHASE_BITS + 4;
	localparam int SH = PHASE_BITS - 16;

	// Configuration registers.
	logic       mode_q;
	logic [7:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			limit_q <= psd_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (psd_pkg::psd_reg_t'(cfg_addr))
				psd_pkg::REG_FOUR_STEP:   mode_q  <= cfg_wdata[0];
				psd_pkg::REG_NOISE_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline control. A stage may load when the output is taken or some
	// stage at or after it is empty, which lets bubbles collapse under a stall.
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic [NS-1:0] vld_in;

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			en[k] = m_tready | !(&(vld_q | ((NS'(1) << k) - NS'(1))));
		end
	end

	assign vld_in = {vld_q[NS-2:0], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vld_in[k];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];

	// Stage 1: extremes, span, sum and the raw phase operands.
	logic [7:0] sa, sb, sc, sd;
	logic [7:0] hi3, lo3, hi, lo;
	logic signed [10:0] xr;
	logic signed [8:0]  yr;

	assign sa = s_tdata[7:0];
	assign sb = s_tdata[15:8];
	assign sc = s_tdata[23:16];
	assign sd = s_tdata[31:24];

	always_comb begin
		hi3 = (sa > sb) ? sa : sb;
		hi3 = (sc > hi3) ? sc : hi3;
		lo3 = (sa < sb) ? sa : sb;
		lo3 = (sc < lo3) ? sc : lo3;
		if (mode_q) begin
			hi = (sd > hi3) ? sd : hi3;
			lo = (sd < lo3) ? sd : lo3;
			xr = $signed({3'b000, sa}) - $signed({3'b000, sc});
			yr = $signed({1'b0, sd}) - $signed({1'b0, sb});
		end else begin
			hi = hi3;
			lo = lo3;
			xr = $signed({2'b00, sb, 1'b0}) - $signed({3'b000, sa}) - $signed({3'b000, sc});
			yr = $signed({1'b0, sa}) - $signed({1'b0, sc});
		end
	end

	logic [7:0]                hi_s1, span_s1;
	logic [psd_pkg::SUM_W-1:0] sum_s1;
	logic signed [10:0]        x_s1;
	logic signed [8:0]         y_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hi_s1   <= hi;
			span_s1 <= hi - lo;
			sum_s1  <= psd_pkg::SUM_W'(sa) + psd_pkg::SUM_W'(sb) + psd_pkg::SUM_W'(sc);
			x_s1    <= xr;
			y_s1    <= yr;
		end
	end

	// Stage 2: background threshold and scaling of the CORDIC operands.
	logic [psd_pkg::PROD_W-1:0] thr;
	logic signed [27:0]         y_sqrt3;

	assign thr     = psd_pkg::PROD_W'(limit_q) * psd_pkg::PROD_W'(sum_s1);
	assign y_sqrt3 = $signed(y_s1) * $signed({1'b0, psd_pkg::SQRT3_Q16});

	logic [7:0]           hi_s2, span_s2;
	logic                 bg_s2, zero_s2;
	logic signed [CW-1:0] x_s2, y_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hi_s2   <= hi_s1;
			span_s2 <= span_s1;
			bg_s2   <= {span_s1, 8'h00} < thr;
			zero_s2 <= (x_s1 == '0) && (y_s1 == '0);
			x_s2    <= {{(CW-27){x_s1[10]}}, x_s1, 16'h0000};
			y_s2    <= mode_q ? {{(CW-25){y_s1[8]}}, y_s1, 16'h0000} : CW'(y_sqrt3);
		end
	end

	// Stage 3: fold the left half plane onto the right by a quarter turn.
	localparam logic signed [AW-1:0] QUARTER = $signed(AW'(1) << (PHASE_BITS - 3));

	psd_pkg::psd_side_t   side_s3;
	logic signed [CW-1:0] x_s3, y_s3;
	logic signed [AW-1:0] a_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s3 <= '{bg: bg_s2, zero: zero_s2, hi: hi_s2, span: span_s2};
			if (x_s2 < 0) begin
				if (y_s2 >= 0) begin
					x_s3 <= y_s2;
					y_s3 <= -x_s2;
					a_s3 <= QUARTER;
				end else begin
					x_s3 <= -y_s2;
					y_s3 <= x_s2;
					a_s3 <= -QUARTER;
				end
			end else begin
				x_s3 <= x_s2;
				y_s3 <= y_s2;
				a_s3 <= '0;
			end
		end
	end

	// CORDIC stages, with the sideband record carried alongside.
	logic signed [AW-1:0] ang;
	psd_pkg::psd_side_t   side_s [PHASE_BITS];

	psd_cordic #(
		.PHASE_BITS (PHASE_BITS)
	) u_cordic (
		.clk     (clk),
		.en      (en[3 +: PHASE_BITS]),
		.x_in    (x_s3),
		.y_in    (y_s3),
		.ang_in  (a_s3),
		.ang_out (ang)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < PHASE_BITS; i++) begin
			if (en[3+i]) side_s[i] <= (i == 0) ? side_s3 : side_s[(i == 0) ? 0 : i-1];
		end
	end

	// Output stage: round the angle to Q0.15 turns, zero the phase of masked or zero-operand pixels.
	logic [15:0] phase_rnd;

	if (SH > 0) begin : g_round
		logic signed [AW-1:0] biased;
		assign biased    = ang + $signed(AW'(1) << (SH - 1));
		assign phase_rnd = 16'(biased >>> SH);
	end else if (SH < 0) begin : g_widen
		assign phase_rnd = 16'(ang) << (-SH);
	end else begin : g_same
		assign phase_rnd = 16'(ang);
	end

	psd_pkg::psd_side_t side_o;
	logic [15:0]        phase_q;
	logic [7:0]         bright_q, span_q;
	logic               bg_q;

	assign side_o = side_s[PHASE_BITS-1];

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			phase_q  <= (side_o.bg || side_o.zero) ? 16'h0000 : phase_rnd;
			bright_q <= side_o.hi;
			span_q   <= side_o.span;
			bg_q     <= side_o.bg;
		end
	end

	assign m_tdata = {span_q, bright_q, phase_q};
	assign m_tuser = bg_q;

	// Checks.
	a_bg_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0000)
		else $error("background pixel with nonzero phase");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) >= -16384) && ($signed(m_tdata[15:0]) <= 16384))
		else $error("wrapped phase outside half a turn");

	a_span_le_bright: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:24] <= m_tdata[23:16])
		else $error("span exceeds brightest sample");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output is free");

endmodule
